[hdl/srsw_pkg.sv]
// ----------------------------------------------------------------------------
// srsw_pkg
// Types, codes and constants shared by the selective-repeat send window block.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  // default sizing
  localparam int unsigned WINDOW_DEF      = 6;
  localparam int unsigned MAX_PACKETS_DEF = 256;

  // field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned SEQ_W   = 14;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PIDX_W  = 8;
  localparam int unsigned PCNT_W  = 9;
  localparam int unsigned IVL_W   = 8;
  localparam int unsigned CMP_W   = 16;

  localparam logic [TIME_W-1:0] SEQ_MASK = TIME_W'((1 << SEQ_W) - 1);
  localparam logic [TAG_W-1:0]  OK_TAG   = 16'h4F4B;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEQ       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESEND_INTERVAL = 2'd2;

  localparam logic [PCNT_W-1:0] PACKET_COUNT_RST    = 9'd1;
  localparam logic [SEQ_W-1:0]  FIRST_SEQ_RST       = 14'd0;
  localparam logic [IVL_W-1:0]  RESEND_INTERVAL_RST = 8'd2;

  // command modes
  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACK   = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_RESEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BADSEQ = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] now_time;
    logic [TAG_W-1:0]  ack_tag;
    logic [SEQ_W-1:0]  ack_seq;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIDX_W-1:0] packet_index;
    logic              last_of_run;
  } res_t;

  typedef struct packed {
    logic [PCNT_W-1:0] packet_count;
    logic [SEQ_W-1:0]  first_seq;
    logic [IVL_W-1:0]  resend_interval;
  } cfg_t;

  // one window store entry
  typedef struct packed {
    logic              acked;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef enum logic {
    UOP_SEQ,
    UOP_AGE
  } unit_op_e;

  typedef struct packed {
    unit_op_e          op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] lim;
  } unit_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic              ge;
  } unit_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLIDE,
    ST_SLIDE_CHK,
    ST_SCAN,
    ST_FIN,
    ST_ACK_RD,
    ST_ACK_WR
  } ctrl_state_e;

endpackage

`default_nettype wire

[hdl/srsw_ram.sv]
// ----------------------------------------------------------------------------
// srsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/srsw_unit.sv]
// ----------------------------------------------------------------------------
// srsw_unit
// Shared subtract-and-compare unit: sequence offsets and send ages.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_unit
  import srsw_pkg::*;
(
  input  wire unit_req_t req_i,
  output unit_rsp_t      rsp_o
);

  logic [TIME_W-1:0] diff_raw;
  logic [TIME_W-1:0] diff;

  always_comb begin
    diff_raw = req_i.a - req_i.b;
    // sequence offsets wrap in the sequence number space
    case (req_i.op)
      UOP_SEQ: diff = diff_raw & SEQ_MASK;
      UOP_AGE: diff = diff_raw;
      default: diff = diff_raw;
    endcase
    rsp_o.diff = diff;
    rsp_o.ge   = (diff >= req_i.lim);
  end

endmodule

`default_nettype wire

[hdl/srsw_ctrl.sv]
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: clearing sweep, window slide, resend scan and ack update.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_ctrl
  import srsw_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned MAX_PACKETS = MAX_PACKETS_DEF,
  localparam int unsigned IDX_W      = $clog2(MAX_PACKETS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire cmd_t              cmd_i,
  input  wire cfg_t              cfg_i,
  output logic                   busy_o,
  output logic                   res_valid_o,
  output res_t                   res_o,
  output unit_req_t              unit_req_o,
  input  wire unit_rsp_t         unit_rsp_i,
  output logic                   ram_we_o,
  output logic       [IDX_W-1:0] ram_waddr_o,
  output entry_t                 ram_wdata_o,
  output logic       [IDX_W-1:0] ram_raddr_o,
  input  wire entry_t            ram_rdata_i
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PACKETS - 1);
  localparam logic [CMP_W-1:0] CNT_MAX  = CMP_W'(MAX_PACKETS);
  localparam logic [CMP_W-1:0] WIN_CNT  = CMP_W'(WINDOW);

  ctrl_state_e       state_q, state_d;
  logic [IDX_W-1:0]  low_q, low_d;
  logic [IDX_W-1:0]  up_q, up_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [IDX_W-1:0]  rd_q, rd_d;
  logic              rd_more_q, rd_more_d;
  logic [IDX_W-1:0]  chk_q, chk_d;
  logic              chk_v_q, chk_v_d;
  logic              pend_v_q, pend_v_d;
  res_t              pend_q, pend_d;
  logic              done_q, done_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [IDX_W-1:0]  ack_idx_q, ack_idx_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  logic [CMP_W-1:0]  pcnt;
  logic [CMP_W-1:0]  eff_cnt;
  logic [CMP_W-1:0]  win_cnt;
  logic [IDX_W-1:0]  mv_low;
  logic [IDX_W-1:0]  mv_up;

  // effective packet count and opening window
  always_comb begin
    pcnt = CMP_W'(cfg_i.packet_count);
    if (pcnt == '0) begin
      eff_cnt = CMP_W'(1);
    end else if (pcnt > CNT_MAX) begin
      eff_cnt = CNT_MAX;
    end else begin
      eff_cnt = pcnt;
    end
    win_cnt = (eff_cnt > WIN_CNT) ? WIN_CNT : eff_cnt;
  end

  // window advance by one; the lower edge stops at the top packet
  always_comb begin
    mv_low = low_q;
    mv_up  = up_q;
    if ((CMP_W'(up_q) + CMP_W'(1)) < eff_cnt) begin
      mv_low = low_q + 1'b1;
      mv_up  = up_q + 1'b1;
    end else if (low_q < up_q) begin
      mv_low = low_q + 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    up_d        = up_q;
    clr_d       = clr_q;
    rd_d        = rd_q;
    rd_more_d   = rd_more_q;
    chk_d       = chk_q;
    chk_v_d     = 1'b0;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    done_d      = done_q;
    now_d       = now_q;
    ack_idx_d   = ack_idx_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = chk_q;
    ram_wdata_o = '0;
    ram_raddr_o = low_q;

    unit_req_o.op  = UOP_SEQ;
    unit_req_o.a   = TIME_W'(cmd_i.ack_seq);
    unit_req_o.b   = TIME_W'(cfg_i.first_seq);
    unit_req_o.lim = TIME_W'(eff_cnt);

    case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        if (clr_q == IDX_LAST) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          case (cmd_i.mode)
            MODE_START: begin
              low_d   = '0;
              up_d    = IDX_W'(win_cnt - CMP_W'(1));
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            MODE_TICK: begin
              now_d   = cmd_i.now_time;
              state_d = ST_SLIDE;
            end
            MODE_ACK: begin
              if (cmd_i.ack_tag == OK_TAG) begin
                if (unit_rsp_i.ge) begin
                  res_valid_d = 1'b1;
                  res_d       = '{kind: KIND_BADSEQ, packet_index: '0, last_of_run: 1'b1};
                end else begin
                  ack_idx_d = IDX_W'(unit_rsp_i.diff);
                  state_d   = ST_ACK_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SLIDE: begin
        if (low_q < up_q) begin
          ram_raddr_o = low_q;
          state_d     = ST_SLIDE_CHK;
        end else begin
          rd_d      = low_q;
          rd_more_d = 1'b1;
          done_d    = 1'b0;
          state_d   = ST_SCAN;
        end
      end

      ST_SLIDE_CHK: begin
        if (ram_rdata_i.acked) begin
          low_d   = mv_low;
          up_d    = mv_up;
          state_d = ST_SLIDE;
        end else begin
          rd_d      = low_q;
          rd_more_d = 1'b1;
          done_d    = 1'b0;
          state_d   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        unit_req_o.op  = UOP_AGE;
        unit_req_o.a   = now_q;
        unit_req_o.b   = ram_rdata_i.stamp;
        unit_req_o.lim = TIME_W'(cfg_i.resend_interval);
        // read the next entry while checking the previous one
        if (rd_more_q) begin
          ram_raddr_o = rd_q;
          chk_d       = rd_q;
          chk_v_d     = 1'b1;
          rd_d        = rd_q + 1'b1;
          rd_more_d   = (rd_q != up_q);
        end
        if (chk_v_q) begin
          if (!ram_rdata_i.acked && unit_rsp_i.ge) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = chk_q;
            ram_wdata_o = '{acked: 1'b0, stamp: now_q};
            // hold one result back so the last one can be flagged
            if (pend_v_q) begin
              res_valid_d = 1'b1;
              res_d       = pend_q;
            end
            pend_d   = '{kind: KIND_RESEND, packet_index: PIDX_W'(chk_q), last_of_run: 1'b0};
            pend_v_d = 1'b1;
          end
          if (chk_q == up_q) begin
            done_d = (low_q == up_q) && ram_rdata_i.acked;
          end
        end
        if (!rd_more_q && !chk_v_q) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (pend_v_q && done_q) begin
          res_valid_d = 1'b1;
          res_d       = pend_q;
          pend_d      = '{kind: KIND_DONE, packet_index: PIDX_W'(up_q), last_of_run: 1'b0};
          done_d      = 1'b0;
        end else if (pend_v_q) begin
          res_valid_d       = 1'b1;
          res_d             = pend_q;
          res_d.last_of_run = 1'b1;
          pend_v_d          = 1'b0;
          state_d           = ST_IDLE;
        end else if (done_q) begin
          res_valid_d = 1'b1;
          res_d       = '{kind: KIND_DONE, packet_index: PIDX_W'(up_q), last_of_run: 1'b1};
          done_d      = 1'b0;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_ACK_RD: begin
        ram_raddr_o = ack_idx_q;
        state_d     = ST_ACK_WR;
      end

      ST_ACK_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ack_idx_q;
        ram_wdata_o = '{acked: 1'b1, stamp: ram_rdata_i.stamp};
        if (ack_idx_q == low_q) begin
          low_d = mv_low;
          up_d  = mv_up;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      low_q       <= '0;
      up_q        <= '0;
      clr_q       <= '0;
      rd_more_q   <= 1'b0;
      chk_v_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      done_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      up_q        <= up_d;
      clr_q       <= clr_d;
      rd_more_q   <= rd_more_d;
      chk_v_q     <= chk_v_d;
      pend_v_q    <= pend_v_d;
      done_q      <= done_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    chk_q     <= chk_d;
    pend_q    <= pend_d;
    now_q     <= now_d;
    ack_idx_q <= ack_idx_d;
    res_q     <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[hdl/selective_repeat_send_window_unit.sv]
// ----------------------------------------------------------------------------
// selective_repeat_send_window_unit
// Sender window of a selective-repeat scheme: tracks acks and send stamps per
// packet, slides the window and reports packets to resend.
// ----------------------------------------------------------------------------
// channel  | ports                                 | transaction when
// ---------+---------------------------------------+---------------------------
// command  | start, busy, cmd_i                    | start high, busy low
// result   | res_valid_o, res_o                    | res_valid_o high (1 cycle)
// config   | cfg_valid_i, cfg_ready_o, cfg_index_i, | cfg_valid_i and cfg_ready_o
//          | cfg_data_i                            |
//
// Ack and send stamp of each packet live in one RAM, one read and one write
// per cycle; that port pair paces the steps below.
// Reset and start commands: clear all MAX_PACKETS entries, busy meanwhile.
// Tick: take the command, read and slide past acked packets at the lower edge,
// scan the window, writing new stamps for packets to resend, then flush
// results. Ack: a valid one in range reads, then updates its RAM entry.
// Results come one per cycle as strobes; the receiver cannot stall them.
// Configuration writes are always taken (cfg_ready_o tied high).
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_send_window_unit
  import srsw_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned MAX_PACKETS = MAX_PACKETS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire cmd_t                  cmd_i,
  output logic                       res_valid_o,
  output res_t                       res_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_PACKETS);

  cfg_t             cfg_q;
  unit_req_t        unit_req;
  unit_rsp_t        unit_rsp;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.packet_count    <= PACKET_COUNT_RST;
      cfg_q.first_seq       <= FIRST_SEQ_RST;
      cfg_q.resend_interval <= RESEND_INTERVAL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PACKET_COUNT:    cfg_q.packet_count    <= cfg_data_i[PCNT_W-1:0];
        REG_FIRST_SEQ:       cfg_q.first_seq       <= cfg_data_i[SEQ_W-1:0];
        REG_RESEND_INTERVAL: cfg_q.resend_interval <= cfg_data_i[IVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srsw_ctrl #(
    .WINDOW      (WINDOW),
    .MAX_PACKETS (MAX_PACKETS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .cfg_i       (cfg_q),
    .busy_o      (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .unit_req_o  (unit_req),
    .unit_rsp_i  (unit_rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  srsw_unit u_unit (
    .req_i (unit_req),
    .rsp_o (unit_rsp)
  );

  srsw_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PACKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
